/* rtl/bitmap_font_text_renderer_assert.svh */
// Assertion macros shared by the renderer modules.
`ifndef BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BFTR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BFTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bftr_pkg.sv */
`default_nettype none
package bftr_pkg;

  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 12;
  localparam int PIX_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CUR_W      = 11;
  localparam int STRIP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TALL_FONT  = 3'd5;

  localparam logic [9:0] RST_BOX_WIDTH  = 10'd128;
  localparam logic [9:0] RST_BOX_HEIGHT = 10'd64;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  localparam logic [CUR_W-1:0] ROW_MAX    = 11'd2047;
  localparam logic [CUR_W-1:0] ROW_STEP_S = 11'd8;
  localparam logic [CUR_W-1:0] ROW_STEP_T = 11'd16;
  localparam logic [CUR_W-1:0] COL_ADV_S  = 11'd8;
  localparam logic [CUR_W-1:0] COL_ADV_T  = 11'd9;

  localparam logic [STRIP_W-1:0] LAST_STRIP_S = 4'd7;
  localparam logic [STRIP_W-1:0] LAST_STRIP_T = 4'd15;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_DRAW
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic test;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_test;
    logic row_over;
    logic slot_free;
    logic last_strip;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/bftr_in_if.sv */
`default_nettype none
interface bftr_in_if;
  import bftr_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic              starts_text;
  logic [CHAR_W-1:0] char_code;
  logic              font_select;
  logic [ADDR_W-1:0] glyph_address;
  logic [7:0]        glyph_data;

  modport source (
    output valid, command, starts_text, char_code, font_select, glyph_address,
           glyph_data,
    input  ready
  );
  modport sink (
    input  valid, command, starts_text, char_code, font_select, glyph_address,
           glyph_data,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/bftr_out_if.sv */
`default_nettype none
interface bftr_out_if;
  import bftr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic [7:0]       column_bits;
  logic             last;

  modport source (
    output valid, pixel_x, pixel_y, column_bits, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, column_bits, last,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/bftr_datapath.sv */
`default_nettype none
`include "bitmap_font_text_renderer_assert.svh"
module bftr_datapath #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bftr_pkg::ctrl_cmd_t                 cmd,
  output bftr_pkg::dp_status_t                st,
  input  logic                                cfg_we,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bftr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                command,
  input  logic                                starts_text,
  input  logic [bftr_pkg::CHAR_W-1:0]         char_code,
  input  logic                                font_select,
  input  logic [bftr_pkg::ADDR_W-1:0]         glyph_address,
  input  logic [7:0]                          glyph_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bftr_pkg::PIX_W-1:0]          pixel_x,
  output logic [bftr_pkg::PIX_W-1:0]          pixel_y,
  output logic [7:0]                          column_bits,
  output logic                                last
);
  import bftr_pkg::*;

  localparam int SMALL_DEPTH = GLYPH_COUNT * 8;
  localparam int TALL_DEPTH  = GLYPH_COUNT * 16;
  localparam int SMALL_AW    = $clog2(SMALL_DEPTH);
  localparam int TALL_AW     = $clog2(TALL_DEPTH);

  // configuration
  logic [9:0] origin_x_r, origin_y_r, box_width_r, box_height_r;
  logic       ink_color_r, tall_font_r;

  // latched item
  logic              command_r, starts_r, fsel_r;
  logic [CHAR_W-1:0] code_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        data_r;

  // cursor
  logic [CUR_W-1:0] col_r, row_r;
  logic             stopped_r;

  logic [PIX_W-1:0]   base_x_r, base_y_r;
  logic [STRIP_W-1:0] k_r;

  logic [7:0]       small_mem [SMALL_DEPTH];
  logic [7:0]       tall_mem  [TALL_DEPTH];
  logic [7:0]       small_q_r, tall_q_r;
  logic             rsel_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] px_r, py_r;
  logic             last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      box_width_r  <= RST_BOX_WIDTH;
      box_height_r <= RST_BOX_HEIGHT;
      ink_color_r  <= 1'b1;
      tall_font_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:   origin_x_r   <= cfg_wdata;
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_wdata;
        CFG_BOX_WIDTH:  box_width_r  <= cfg_wdata;
        CFG_BOX_HEIGHT: box_height_r <= cfg_wdata;
        CFG_INK_COLOR:  ink_color_r  <= cfg_wdata[0];
        CFG_TALL_FONT:  tall_font_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      command_r <= command;
      starts_r  <= starts_text;
      code_r    <= char_code;
      fsel_r    <= font_select;
      addr_r    <= glyph_address;
      data_r    <= glyph_data;
    end
  end

  // item evaluation: apply start of text first, then newline or wrap
  logic [CUR_W-1:0] col_eff, row_eff, row_step, row_sat, col_adv;
  logic [CUR_W:0]   row_sum;
  logic             stp_eff, is_nl, in_range, wrap, is_draw, go_test, row_over, move_row;

  always_comb begin
    col_eff  = starts_r ? '0 : col_r;
    row_eff  = starts_r ? '0 : row_r;
    stp_eff  = starts_r ? 1'b0 : stopped_r;
    row_step = tall_font_r ? ROW_STEP_T : ROW_STEP_S;
    col_adv  = tall_font_r ? COL_ADV_T : COL_ADV_S;
    row_sum  = {1'b0, row_eff} + {1'b0, row_step};
    row_sat  = row_sum[CUR_W] ? ROW_MAX : row_sum[CUR_W-1:0];
    is_nl    = (code_r == CHAR_NEWLINE);
    in_range = ({1'b0, code_r} < 9'(GLYPH_COUNT));
    wrap     = (col_eff >= {1'b0, box_width_r});
    is_draw  = (command_r == CMD_DRAW);
    go_test  = is_draw && !stp_eff && !is_nl && in_range;
    move_row = !stp_eff && (is_nl || (in_range && wrap));
    row_over = (row_r >= {1'b0, box_height_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      stopped_r <= 1'b0;
    end else if (cmd.check && is_draw) begin
      stopped_r <= stp_eff;
      if (move_row) begin
        row_r <= row_sat;
        col_r <= '0;
      end else begin
        row_r <= row_eff;
        col_r <= col_eff;
      end
    end else if (cmd.test) begin
      if (row_over) begin
        stopped_r <= 1'b1;
      end else begin
        col_r <= col_r + col_adv;
      end
    end
  end

  // strip sequencing
  logic [2:0]         strip_col;
  logic               strip_byte, last_strip;
  logic [10:0]        small_full;
  logic [11:0]        tall_full;
  logic [SMALL_AW-1:0] small_raddr, small_waddr;
  logic [TALL_AW-1:0]  tall_raddr, tall_waddr;
  logic               small_we, tall_we, slot_free;

  always_comb begin
    strip_col   = tall_font_r ? k_r[3:1] : k_r[2:0];
    strip_byte  = tall_font_r & k_r[0];
    last_strip  = (k_r == (tall_font_r ? LAST_STRIP_T : LAST_STRIP_S));
    small_full  = {code_r, k_r[2:0]};
    tall_full   = {code_r, k_r};
    small_raddr = small_full[SMALL_AW-1:0];
    tall_raddr  = tall_full[TALL_AW-1:0];
    small_waddr = addr_r[SMALL_AW-1:0];
    tall_waddr  = addr_r[TALL_AW-1:0];
    small_we    = cmd.check && (command_r == CMD_LOAD) && !fsel_r &&
                  ({1'b0, addr_r} < 13'(SMALL_DEPTH));
    tall_we     = cmd.check && (command_r == CMD_LOAD) && fsel_r &&
                  ({1'b0, addr_r} < 13'(TALL_DEPTH));
    slot_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      base_x_r <= PIX_W'(origin_x_r) + PIX_W'(col_r);
      base_y_r <= PIX_W'(origin_y_r) + PIX_W'(row_r);
      k_r      <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + STRIP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (small_we) small_mem[small_waddr] <= data_r;
    if (cmd.issue && !tall_font_r) small_q_r <= small_mem[small_raddr];
  end

  always_ff @(posedge clk) begin
    if (tall_we) tall_mem[tall_waddr] <= data_r;
    if (cmd.issue && tall_font_r) tall_q_r <= tall_mem[tall_raddr];
  end

  // read data register doubles as the output beat's payload
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      px_r   <= base_x_r + PIX_W'(strip_col);
      py_r   <= base_y_r + (strip_byte ? PIX_W'(8) : PIX_W'(0));
      last_r <= last_strip;
      rsel_r <= tall_font_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.issue || (out_valid_r && !out_ready);
    end
  end

  logic [7:0] glyph_q;
  assign glyph_q     = rsel_r ? tall_q_r : small_q_r;
  assign column_bits = ink_color_r ? glyph_q : ~glyph_q;
  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign last        = last_r;
  assign out_valid   = out_valid_r;

  assign st.go_test    = go_test;
  assign st.row_over   = row_over;
  assign st.slot_free  = slot_free;
  assign st.last_strip = last_strip;

  `BFTR_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.issue, !out_valid_r || out_ready, "strip issued over a held beat")
  `BFTR_ASSERT_NEXT(a_load_keeps_cursor, clk, rst_n, cmd.check && (command_r == CMD_LOAD), $stable(col_r) && $stable(row_r) && $stable(stopped_r), "font load moved the cursor")
  `BFTR_ASSERT_NEXT(a_issue_presents, clk, rst_n, cmd.issue, out_valid_r, "issued strip not presented")

endmodule
`default_nettype wire

/* rtl/bftr_ctrl.sv */
`default_nettype none
`include "bitmap_font_text_renderer_assert.svh"
module bftr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bftr_pkg::dp_status_t  st,
  output bftr_pkg::ctrl_cmd_t   cmd
);
  import bftr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        // hold the input closed while reset is applied
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = st.go_test ? S_TEST : S_IDLE;
      end
      S_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = st.row_over ? S_IDLE : S_DRAW;
      end
      S_DRAW: begin
        // advance one strip whenever the output register frees up
        if (st.slot_free) begin
          cmd.issue = 1'b1;
          if (st.last_strip) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `BFTR_ASSERT_NEXT(a_accept_checks, clk, rst_n, in_valid && in_ready, state_r == S_CHECK, "accepted item not evaluated")
  `BFTR_ASSERT_NEXT(a_last_frees_input, clk, rst_n, cmd.issue && st.last_strip, in_ready, "input not reopened after last strip")
  `BFTR_ASSERT_IMPL(a_ready_in_idle, clk, rst_n, in_ready, state_r == S_IDLE, "input ready outside idle")

endmodule
`default_nettype wire

/* rtl/bitmap_font_text_renderer.sv */
// Character generator with loadable 8x8 and 8x16 fonts.
// in_ch carries commands (valid/ready): a load writes one font byte, a draw
// places one character at the text cursor. out_ch carries vertical 8-pixel
// strips (valid/ready), last marks the final strip of a character.
// cfg_we/cfg_index/cfg_wdata write the box, ink and font registers; write
// them only while no item is in flight.
// Sequencing: a load occupies the input for the idle (accept) and check states.
// A draw passes the idle, check and test states, then, unless the row is past
// the box, issues one strip per cycle while out_ch does not stall. The strip
// rate is set by the single read port of each font memory. Newlines and ignored
// characters pass the idle and check states and emit nothing. The first strip
// is presented from the output register after the first issue in the draw state.
// The next item is accepted while the last strip still waits in the output
// register. When out_ch stalls, strip issue pauses and nothing is dropped.
// Reset (rst_n low, synchronous) restores the registers and homes the cursor;
// font contents are not cleared and must be loaded before use.
`default_nettype none
module bitmap_font_text_renderer #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bftr_in_if.sink                         in_ch,
  bftr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bftr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bftr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  bftr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  bftr_datapath #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .command       (in_ch.command),
    .starts_text   (in_ch.starts_text),
    .char_code     (in_ch.char_code),
    .font_select   (in_ch.font_select),
    .glyph_address (in_ch.glyph_address),
    .glyph_data    (in_ch.glyph_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pixel_x       (out_ch.pixel_x),
    .pixel_y       (out_ch.pixel_y),
    .column_bits   (out_ch.column_bits),
    .last          (out_ch.last)
  );

endmodule
`default_nettype wire
